@@ hw/rtl/tmavg_pkg.sv @@
// tmavg_pkg: shared types and constants for the three-axis moving average
// sample and result payloads, the queue entry between front and back
`timescale 1ns / 1ps

package tmavg_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int AXES        = 3;
	localparam int WINDOW_DEF  = 35;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] avg_x;
		logic signed [SAMPLE_W-1:0] avg_y;
		logic signed [SAMPLE_W-1:0] avg_z;
	} result_t;

	// new sample and the sample it overwrote in the window
	typedef struct packed {
		sample_t fresh;
		sample_t stale;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

@@ hw/rtl/tmavg_front.sv @@
// tmavg_front: takes samples, writes the window memory, reads the overwritten entry
// depends on tmavg_pkg
`timescale 1ns / 1ps

module tmavg_front import tmavg_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sample_valid,
	output logic     sample_stall,
	input  sample_t  sample,
	input  q_stat_t  q_stat,
	output logic     q_push,
	output q_entry_t q_data
);

	localparam int SLOT_W = $clog2(WINDOW);

	sample_t           ring [WINDOW];
	logic [WINDOW-1:0] written_q;
	logic [SLOT_W-1:0] slot_q;
	logic              accept;
	logic              valid_s1;
	sample_t           fresh_s1;
	sample_t           rd_data_s1;
	logic              rd_written_s1;

	assign sample_stall = valid_s1 && q_stat.full;
	assign accept       = sample_valid && !sample_stall;
	assign q_push       = valid_s1 && !q_stat.full;

	// entries never written since reset read as zero
	assign q_data.fresh = fresh_s1;
	assign q_data.stale = rd_written_s1 ? rd_data_s1 : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			ring[slot_q] <= sample;
			rd_data_s1   <= ring[slot_q];
			fresh_s1     <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q     <= '0;
			slot_q        <= '0;
			valid_s1      <= 1'b0;
			rd_written_s1 <= 1'b0;
		end else begin
			if (accept) begin
				written_q[slot_q] <= 1'b1;
				rd_written_s1     <= written_q[slot_q];
				if (slot_q == SLOT_W'(WINDOW - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/tmavg_queue.sv @@
// tmavg_queue: short fifo between the front and the back
// depends on tmavg_pkg
`timescale 1ns / 1ps

module tmavg_queue import tmavg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	input  logic     pop,
	output q_entry_t head,
	output q_stat_t  stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	q_entry_t         slots [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign head          = slots[rd_ptr_q];
	assign stat.full     = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign stat.nonempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/tmavg_back.sv @@
// tmavg_back: running window sums, divide by the window length, result register
// depends on tmavg_pkg
`timescale 1ns / 1ps

module tmavg_back import tmavg_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  q_entry_t head,
	input  q_stat_t  q_stat,
	output logic     q_pop,
	output logic     avg_valid,
	input  logic     avg_stall,
	output result_t  average
);

	localparam int LOG_W   = $clog2(WINDOW);
	localparam int SUM_W   = SAMPLE_W + LOG_W;
	localparam int SHIFT   = SUM_W + LOG_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int QUOT_W  = SAMPLE_W + 1;
	// ceiling reciprocal, exact for magnitudes below 2**SUM_W
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	logic                        en;
	logic                        valid_s1;
	logic                        valid_s2;
	logic signed [SAMPLE_W-1:0]  fresh_ax [AXES];
	logic signed [SAMPLE_W-1:0]  stale_ax [AXES];
	logic signed [SUM_W-1:0]     sum_q    [AXES];
	logic        [SUM_W-1:0]     mag      [AXES];
	logic        [PROD_W-1:0]    prod_s2  [AXES];
	logic        [AXES-1:0]      neg_s2;
	logic        [QUOT_W-1:0]    quot     [AXES];
	logic signed [SAMPLE_W-1:0]  avg_ax   [AXES];
	logic                        out_valid_q;
	result_t                     out_q;

	assign en    = !(out_valid_q && avg_stall);
	assign q_pop = q_stat.nonempty && en;

	assign fresh_ax[0] = head.fresh.accel_x;
	assign fresh_ax[1] = head.fresh.accel_y;
	assign fresh_ax[2] = head.fresh.accel_z;
	assign stale_ax[0] = head.stale.accel_x;
	assign stale_ax[1] = head.stale.accel_y;
	assign stale_ax[2] = head.stale.accel_z;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			mag[a]    = sum_q[a][SUM_W-1] ? SUM_W'(-sum_q[a]) : SUM_W'(sum_q[a]);
			quot[a]   = prod_s2[a][SHIFT +: QUOT_W];
			avg_ax[a] = neg_s2[a] ? SAMPLE_W'(-quot[a]) : SAMPLE_W'(quot[a]);
		end
	end

	// sum_q is the stage 1 payload: it updates only when an entry is popped and holds otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else if (q_pop) begin
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= sum_q[a] + SUM_W'(fresh_ax[a]) - SUM_W'(stale_ax[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				prod_s2[a] <= PROD_W'(mag[a]) * PROD_W'(RECIP);
				neg_s2[a]  <= sum_q[a][SUM_W-1];
			end
			out_q.avg_x <= avg_ax[0];
			out_q.avg_y <= avg_ax[1];
			out_q.avg_z <= avg_ax[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= q_pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign avg_valid = out_valid_q;
	assign average   = out_q;

endmodule

@@ hw/rtl/three_axis_moving_average.sv @@
// three_axis_moving_average: top level of the boxcar filter over x, y and z
// depends on tmavg_pkg, tmavg_front, tmavg_queue, tmavg_back
`timescale 1ns / 1ps

// Boxcar moving average over the last WINDOW samples of each accelerometer axis.
// One sample request is taken per clock unless stalled and gives exactly one
// average request; the window starts out as all zeros after reset, so early
// averages lean toward zero. Averages truncate toward zero. Throughput is one
// sample per cycle unless stalled, set by the running-sum update; a sample
// passes the memory read, queue, sum update, reciprocal multiply and result
// register. Each accepted sample writes and reads one slot of the window memory;
// a per-entry written flag stands in for clearing, so no reset sweep is needed.
// A four-entry queue lets sample intake continue while the result side stalls.
module three_axis_moving_average import tmavg_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	output logic    avg_valid,
	input  logic    avg_stall,
	output result_t average
);

	logic     q_push;
	logic     q_pop;
	q_entry_t q_push_data;
	q_entry_t q_head;
	q_stat_t  q_stat;

	tmavg_front #(.WINDOW(WINDOW)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_stat       (q_stat),
		.q_push       (q_push),
		.q_data       (q_push_data)
	);

	tmavg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	tmavg_back #(.WINDOW(WINDOW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.avg_valid (avg_valid),
		.avg_stall (avg_stall),
		.average   (average)
	);

	// the queue never takes a request while full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");

	// sample intake stalls only on a full queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> q_stat.full)
		else $error("sample stall without full queue");

	// an emptied queue with nothing pushed stays empty
	a_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_stat.nonempty && !q_push) |=> !q_stat.nonempty)
		else $error("queue filled without a push");

endmodule

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for the three-axis boxcar moving average
// depends on tmavg_pkg and three_axis_moving_average; keeps its own window and running sums
`timescale 1ns / 1ps

module testbench;
	import tmavg_pkg::*;

	localparam int WINDOW      = WINDOW_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_LIMIT  = 10;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample       = '0;
	logic    avg_valid;
	logic    avg_stall    = 1'b0;
	result_t average;

	// golden copy of the filter state
	sample_t window_ring [WINDOW];
	int      ring_slot = 0;
	longint  axis_sum [3];

	result_t pending_avgs [$];
	int      fail_count  = 0;
	int      cycle_count = 0;

	int      send_idle_pct = 0;
	int      stall_pct     = 0;
	int      hold_len      = 0;
	logic [7:0] hold_seq   = '0;
	logic [7:0] hold_seen  = '0;
	int      hold_left     = 0;

	three_axis_moving_average dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.avg_valid    (avg_valid),
		.avg_stall    (avg_stall),
		.average      (average)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		foreach (window_ring[i])
			window_ring[i] = '0;
		foreach (axis_sum[i])
			axis_sum[i] = 0;
	end

	function automatic sample_t mk_sample(input int x, input int y, input int z);
		sample_t s;
		s.accel_x = x[15:0];
		s.accel_y = y[15:0];
		s.accel_z = z[15:0];
		return s;
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(2))
			0: return -32768;
			1: return 32767;
			default: return int'($urandom);
		endcase
	endfunction

	// running sum update: add the new sample, drop the one it overwrites
	function automatic result_t predict_average(input sample_t s);
		longint  fresh [3];
		longint  stale [3];
		longint  quot [3];
		result_t r;
		fresh[0] = longint'(s.accel_x);
		fresh[1] = longint'(s.accel_y);
		fresh[2] = longint'(s.accel_z);
		stale[0] = longint'(window_ring[ring_slot].accel_x);
		stale[1] = longint'(window_ring[ring_slot].accel_y);
		stale[2] = longint'(window_ring[ring_slot].accel_z);
		for (int a = 0; a < 3; a++) begin
			axis_sum[a] = axis_sum[a] + fresh[a] - stale[a];
			// signed division truncates toward zero
			quot[a] = axis_sum[a] / WINDOW;
		end
		window_ring[ring_slot] = s;
		ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
		r.avg_x = quot[0][15:0];
		r.avg_y = quot[1][15:0];
		r.avg_z = quot[2][15:0];
		return r;
	endfunction

	// predict on accepted samples, check accepted averages
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				pending_avgs.push_back(predict_average(sample));
			if (avg_valid && !avg_stall) begin
				if (pending_avgs.size() == 0) begin
					if (fail_count < SHOW_LIMIT)
						$display("unexpected average x=%0d y=%0d z=%0d",
							average.avg_x, average.avg_y, average.avg_z);
					fail_count++;
				end else begin
					want = pending_avgs.pop_front();
					if (want.avg_x !== average.avg_x || want.avg_y !== average.avg_y ||
							want.avg_z !== average.avg_z) begin
						if (fail_count < SHOW_LIMIT)
							$display("average mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
								want.avg_x, want.avg_y, want.avg_z,
								average.avg_x, average.avg_y, average.avg_z);
						fail_count++;
					end
				end
			end
		end
	end

	// result side stall, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= hold_len;
			avg_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			avg_stall <= 1'b1;
		end else begin
			avg_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// returns right after the edge that takes the request; valid is left high
	task automatic send_sample(input sample_t s);
		if ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			sample <= mk_sample($urandom, $urandom, $urandom);
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_avgs.size() != 0);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct <= recv_pct;
	endtask

	task automatic run_random(input int count);
		int      left;
		int      kind;
		int      run_len;
		sample_t held;
		sample_t s;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(9);
			case (kind)
				0, 1, 2, 3: run_len = $urandom_range(20, 1);
				4, 5:       run_len = $urandom_range(45, 35);
				6:          run_len = $urandom_range(40, 10);
				default:    run_len = $urandom_range(50, 35);
			endcase
			if (kind == 4 || kind == 5)
				held = mk_sample(pick_extreme(), pick_extreme(), pick_extreme());
			else
				held = mk_sample($urandom, $urandom, $urandom);
			for (int i = 0; i < run_len && left > 0; i++) begin
				case (kind)
					0, 1, 2, 3: s = mk_sample($urandom, $urandom, $urandom);
					// values near zero exercise truncation of negative sums
					6: s = mk_sample(int'($urandom_range(80)) - 40,
						int'($urandom_range(80)) - 40, int'($urandom_range(80)) - 40);
					default: s = held;
				endcase
				send_sample(s);
				left--;
			end
		end
	endtask

	// early samples average in the zeros left by reset
	task automatic test_directed();
		set_idling(0, 0);
		send_sample(mk_sample(0, 0, 0));
		send_sample(mk_sample(-1, 1, -1));
		send_sample(mk_sample(-35, 35, -34));
		send_sample(mk_sample(-36, 36, 70));
		send_sample(mk_sample(32767, -32768, 0));
		send_sample(mk_sample(-32768, 32767, -1));
		send_sample(mk_sample(32767, 32767, 32767));
		send_sample(mk_sample(-32768, -32768, -32768));
		send_sample(mk_sample(21845, -21846, 1));
		send_sample(mk_sample(-21846, 21845, -2));
		send_sample(mk_sample(1, -1, 34));
		send_sample(mk_sample(-34, 34, 35));
		send_sample(mk_sample(256, -256, 4096));
		send_sample(mk_sample(-4096, 16384, -16384));
		send_sample(mk_sample(12345, -12345, 0));
		send_sample(mk_sample(100, -100, 7));
		send_sample(mk_sample(-7, 7, -100));
		send_sample(mk_sample(32767, 0, -32768));
		send_sample(mk_sample(0, -32768, 32767));
		send_sample(mk_sample(-1, -1, -1));
		wait_drained();
	endtask

	task automatic test_random_phases();
		set_idling(0, 0);
		run_random(257);
		wait_drained();
		set_idling(57, 0);
		run_random(257);
		wait_drained();
		set_idling(0, 57);
		run_random(257);
		wait_drained();
		set_idling(34, 34);
		run_random(257);
		wait_drained();
	endtask

	// result side holds off while samples keep coming, so intake must stall
	task automatic test_backpressure();
		set_idling(0, 0);
		hold_len <= 300;
		hold_seq <= hold_seq + 8'd1;
		run_random(60);
		wait_drained();
	endtask

	task automatic test_sender_pause();
		set_idling(34, 34);
		repeat (2) begin
			run_random(20);
			wait_drained();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phases();
		test_backpressure();
		test_sender_pause();
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_avgs.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
